@@ hdl/pvc_pkg.sv @@
// ----------------------------------------------------------------------------
// pvc_pkg
// shared types and constants for the package version compare block
// ----------------------------------------------------------------------------
`default_nettype none
package pvc_pkg;
	localparam int MAX_LEN = 64;
	localparam int AW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN + 1);

	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	typedef enum logic [3:0] {
		ST_LOAD, ST_COLON_A, ST_COLON_B, ST_DASH_A, ST_DASH_B,
		ST_PART, ST_NONDIG, ST_ZERO, ST_DIGIT, ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		REL_ANY = 3'd0, REL_EQ = 3'd1, REL_LT = 3'd2,
		REL_LE = 3'd3, REL_GT = 3'd4, REL_GE = 3'd5
	} rel_t;

	function automatic logic is_dig(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic signed [9:0] weight(input logic [7:0] c);
		if (c == 8'h7e) return -10'sd1;
		if (is_dig(c) || c == 8'h00) return 10'sd0;
		if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a))
			return signed'({2'b00, c});
		return signed'({2'b01, c});
	endfunction
endpackage
`default_nettype wire

@@ hdl/pvc_buf.sv @@
// ----------------------------------------------------------------------------
// pvc_buf
// one string buffer with registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module pvc_buf (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [pvc_pkg::AW-1:0] waddr,
	input  wire logic [7:0]           wdata,
	input  wire logic [pvc_pkg::AW-1:0] raddr,
	output logic      [7:0]           rdata
);
	import pvc_pkg::*;
	logic [7:0] mem_q [MAX_LEN];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/package_version_compare_top.sv @@
// ----------------------------------------------------------------------------
// package_version_compare_top
// debian version comparison of two streamed strings
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tdata: char_a, valid_a, char_b, valid_b, relation, first_exists
//               tlast: last
// m_axis   out  tdata: order, holds, overflow
// loading takes one request per cycle; on last the sequencer scans both
// buffers with one memory read per buffer per step, a read then a compare:
// colon search from the front, dash search from the end, then the parts
// walked character by character, after a setup state per part, to a done state.
// not ready from last until the result register is free.
// reset clears lengths, overflow flag, result register and the sequencer.
`default_nettype none
module package_version_compare_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// char_a[7:0], valid_a[8], char_b[16:9], valid_b[17], relation[20:18],
	// first_exists[21]
	input  wire logic [23:0] s_axis_tdata,
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// order[1:0], holds[2], overflow[3]
	output logic [7:0]       m_axis_tdata
);
	import pvc_pkg::*;
	state_t st_q, st_d;
	logic [LW-1:0] len_a_q, len_b_q;
	logic [LW-1:0] ia_q, ib_q, ae_q, be_q;
	logic [LW-1:0] ea_q, eb_q, ua_q, ub_q, va_q, vb_q, ra_q, rb_q;
	logic [LW-1:0] pa, pb;
	logic [1:0] part_q;
	logic ovf_q, ex_q, fd_q, fdn_q, rd_q;
	logic [2:0] rel_q;
	logic signed [1:0] r_q;
	logic [7:0] xa, xb;
	logic acc, wa, wb;
	logic ina, inb, da, db, nda, ndb;
	logic signed [9:0] wa_c, wb_c;
	logic hold, out_free;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = st_q == ST_LOAD;
	assign wa = acc && s_axis_tdata[8] && len_a_q < LW'(MAX_LEN);
	assign wb = acc && s_axis_tdata[17] && len_b_q < LW'(MAX_LEN);
	assign pa = (st_q == ST_DASH_A) ? ia_q - 1'b1 : ia_q;
	assign pb = (st_q == ST_DASH_B) ? ib_q - 1'b1 : ib_q;
	pvc_buf u_a (.clk, .we(wa), .waddr(len_a_q[AW-1:0]), .wdata(s_axis_tdata[7:0]),
		.raddr(pa[AW-1:0]), .rdata(xa));
	pvc_buf u_b (.clk, .we(wb), .waddr(len_b_q[AW-1:0]), .wdata(s_axis_tdata[16:9]),
		.raddr(pb[AW-1:0]), .rdata(xb));
	assign ina = ia_q < ae_q;
	assign inb = ib_q < be_q;
	assign da = ina && is_dig(xa);
	assign db = inb && is_dig(xb);
	assign nda = ina && !is_dig(xa);
	assign ndb = inb && !is_dig(xb);
	assign wa_c = ina ? weight(xa) : 10'sd0;
	assign wb_c = inb ? weight(xb) : 10'sd0;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_LOAD;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_LOAD:    if (acc && s_axis_tlast) st_d = ST_COLON_A;
			ST_COLON_A: if ((!rd_q && ia_q == len_a_q) || (rd_q && xa == CH_COLON))
				st_d = ST_COLON_B;
			ST_COLON_B: if ((!rd_q && ib_q == len_b_q) || (rd_q && xb == CH_COLON))
				st_d = ST_DASH_A;
			ST_DASH_A:  if ((!rd_q && ia_q <= ua_q + 1'b1) || (rd_q && xa == CH_DASH))
				st_d = ST_DASH_B;
			ST_DASH_B:  if ((!rd_q && ib_q <= ub_q + 1'b1) || (rd_q && xb == CH_DASH))
				st_d = ST_PART;
			ST_PART:    st_d = ST_NONDIG;
			ST_NONDIG: if (rd_q) begin
				if (!ina && !inb) st_d = (part_q == 2'd2) ? ST_DONE : ST_PART;
				else if (nda || ndb) begin
					if (wa_c != wb_c) st_d = ST_DONE;
				end else st_d = ST_ZERO;
			end
			ST_ZERO: if (rd_q && !(ina && xa == CH_ZERO) && !(inb && xb == CH_ZERO))
				st_d = ST_DIGIT;
			ST_DIGIT: if (rd_q && !(da && db))
				st_d = (da || db || fdn_q) ? ST_DONE : ST_NONDIG;
			ST_DONE:    if (out_free) st_d = ST_LOAD;
			default:    st_d = ST_LOAD;
		endcase
	end

	// load counters and scan engine: one buffer read per step, issued then compared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q <= '0; len_b_q <= '0; ovf_q <= 1'b0; rd_q <= 1'b0; part_q <= '0;
			ia_q <= '0; ib_q <= '0; ae_q <= '0; be_q <= '0;
			ea_q <= '0; eb_q <= '0; ua_q <= '0; ub_q <= '0;
			va_q <= '0; vb_q <= '0; ra_q <= '0; rb_q <= '0;
			rel_q <= '0; ex_q <= 1'b0; fd_q <= 1'b0; fdn_q <= 1'b0; r_q <= '0;
		end else begin
			case (st_q)
			ST_LOAD: if (acc) begin
				if (wa) len_a_q <= len_a_q + 1'b1;
				if (wb) len_b_q <= len_b_q + 1'b1;
				if ((s_axis_tdata[8] && !wa) || (s_axis_tdata[17] && !wb)) ovf_q <= 1'b1;
				rel_q <= s_axis_tdata[20:18]; ex_q <= s_axis_tdata[21];
				ia_q <= '0; ib_q <= '0; rd_q <= 1'b0; part_q <= '0;
			end
			ST_COLON_A: begin
				if (!rd_q) begin
					if (ia_q == len_a_q) begin ea_q <= '0; ua_q <= '0; end
					else rd_q <= 1'b1;
				end else begin
					rd_q <= 1'b0;
					if (xa == CH_COLON) begin
						ea_q <= ia_q; ua_q <= (ia_q == '0) ? '0 : ia_q + 1'b1;
						ia_q <= len_a_q;
					end else ia_q <= ia_q + 1'b1;
				end
				if (!rd_q && ia_q == len_a_q) ia_q <= len_a_q;
			end
			ST_COLON_B: begin
				if (!rd_q) begin
					if (ib_q == len_b_q) begin eb_q <= '0; ub_q <= '0; end
					else rd_q <= 1'b1;
				end else begin
					rd_q <= 1'b0;
					if (xb == CH_COLON) begin
						eb_q <= ib_q; ub_q <= (ib_q == '0) ? '0 : ib_q + 1'b1;
						ib_q <= len_b_q;
					end else ib_q <= ib_q + 1'b1;
				end
			end
			ST_DASH_A: begin
				if (!rd_q) begin
					if (ia_q <= ua_q + 1'b1) begin va_q <= len_a_q; ra_q <= len_a_q; end
					else rd_q <= 1'b1;
				end else begin
					rd_q <= 1'b0;
					if (xa == CH_DASH) begin va_q <= ia_q - 1'b1; ra_q <= ia_q; end
					else ia_q <= ia_q - 1'b1;
				end
			end
			ST_DASH_B: begin
				if (!rd_q) begin
					if (ib_q <= ub_q + 1'b1) begin vb_q <= len_b_q; rb_q <= len_b_q; end
					else rd_q <= 1'b1;
				end else begin
					rd_q <= 1'b0;
					if (xb == CH_DASH) begin vb_q <= ib_q - 1'b1; rb_q <= ib_q; end
					else ib_q <= ib_q - 1'b1;
				end
			end
			ST_PART: begin
				case (part_q)
					2'd0: begin ia_q <= '0; ae_q <= ea_q; ib_q <= '0; be_q <= eb_q; end
					2'd1: begin ia_q <= ua_q; ae_q <= va_q; ib_q <= ub_q; be_q <= vb_q; end
					default: begin ia_q <= ra_q; ae_q <= len_a_q; ib_q <= rb_q; be_q <= len_b_q; end
				endcase
				fdn_q <= 1'b0; fd_q <= 1'b0;
			end
			ST_NONDIG: begin
				if (!rd_q) rd_q <= 1'b1;
				else begin
					rd_q <= 1'b0;
					if (!ina && !inb) begin
						if (part_q == 2'd2) r_q <= 2'sd0; else part_q <= part_q + 1'b1;
					end else if (nda || ndb) begin
						if (wa_c != wb_c) r_q <= (wa_c > wb_c) ? 2'sd1 : -2'sd1;
						else begin
							if (ina) ia_q <= ia_q + 1'b1;
							if (inb) ib_q <= ib_q + 1'b1;
						end
					end
				end
			end
			ST_ZERO: begin
				if (!rd_q) rd_q <= 1'b1;
				else begin
					rd_q <= 1'b0;
					if (ina && xa == CH_ZERO) ia_q <= ia_q + 1'b1;
					else if (inb && xb == CH_ZERO) ib_q <= ib_q + 1'b1;
				end
			end
			ST_DIGIT: begin
				if (!rd_q) rd_q <= 1'b1;
				else begin
					rd_q <= 1'b0;
					if (da && db) begin
						if (!fdn_q && xa != xb) begin fdn_q <= 1'b1; fd_q <= xa > xb; end
						ia_q <= ia_q + 1'b1; ib_q <= ib_q + 1'b1;
					end else if (da) r_q <= 2'sd1;
					else if (db) r_q <= -2'sd1;
					else if (fdn_q) r_q <= fd_q ? 2'sd1 : -2'sd1;
				end
			end
			ST_DONE: if (out_free) begin
				len_a_q <= '0; len_b_q <= '0; ovf_q <= 1'b0;
			end
			default: ;
			endcase
		end
	end

	always_comb begin
		case (rel_q)
			REL_ANY: hold = ex_q;
			REL_EQ:  hold = r_q == 2'sd0;
			REL_LT:  hold = r_q < 2'sd0;
			REL_LE:  hold = r_q <= 2'sd0;
			REL_GT:  hold = r_q > 2'sd0;
			REL_GE:  hold = r_q >= 2'sd0;
			default: hold = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
			m_axis_tdata <= '0;
		end else if (st_q == ST_DONE && out_free) begin
			m_axis_tvalid <= 1'b1;
			m_axis_tdata <= {4'd0, ovf_q, hold, r_q};
		end else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end
`ifndef SYNTHESIS
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while waiting");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'b10) else $error("order code");
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		len_a_q <= LW'(MAX_LEN) && len_b_q <= LW'(MAX_LEN)) else $error("length");
`endif
endmodule
`default_nettype wire
